FILE: rtl/mpdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdl_pkg
// Shared widths, codes and types of the lockout debouncer.
// ----------------------------------------------------------------------------
package mpdl_pkg;

  // field and bus widths
  localparam int MODE_W    = 2;
  localparam int TIME_IN_W = 32;
  localparam int PIN_W     = 8;
  localparam int QPIN_W    = 3;
  localparam int CTR_W     = 16;
  localparam int DEB_W     = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;

  // parameter defaults
  localparam int DEF_NUM_PINS   = 8;
  localparam int DEF_TIME_WIDTH = 32;

  // reset values and limits
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(50);
  localparam logic [PIN_W-1:0] ENABLED_RESET  = '0;
  localparam logic [CTR_W-1:0] CTR_MAX        = '1;

  // item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE     = 2'd0,
    MODE_QUERY      = 2'd1,
    MODE_RD_PHANTOM = 2'd2,
    MODE_RD_BOUNCE  = 2'd3
  } mode_t;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ENABLED  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 1'd1;

  // command to one pin cell
  typedef struct packed {
    logic do_sample;
    logic do_query;
    logic level;
    logic want;
  } pin_cmd_t;

  // status back from one pin cell
  typedef struct packed {
    logic activity;
    logic bounce;
    logic hit;
  } pin_stat_t;

endpackage
`default_nettype wire

FILE: rtl/mpdl_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdl_regs
// Configuration registers on the APB-style port: pin enable mask and lockout.
// ----------------------------------------------------------------------------
module mpdl_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mpdl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mpdl_pkg::DATA_W-1:0] pwdata,
  output logic      [mpdl_pkg::DATA_W-1:0] prdata,
  output logic      [mpdl_pkg::PIN_W-1:0]  enabled_pins,
  output logic      [mpdl_pkg::DEB_W-1:0]  debounce_ms
);
  import mpdl_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_beat;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_beat = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_pins <= ENABLED_RESET;
      debounce_ms  <= DEBOUNCE_RESET;
    end else if (wr_beat) begin
      case (reg_idx)
        REG_ENABLED:  enabled_pins <= pwdata[PIN_W-1:0];
        REG_DEBOUNCE: debounce_ms  <= pwdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_ENABLED:  prdata = DATA_W'(enabled_pins);
      REG_DEBOUNCE: prdata = DATA_W'(debounce_ms);
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mpdl_pin_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdl_pin_cell
// State and next-state logic of one debounced pin: stable and pending level,
// event flag and lockout deadline.
// ----------------------------------------------------------------------------
module mpdl_pin_cell #(
  parameter int TIME_WIDTH = mpdl_pkg::DEF_TIME_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mpdl_pkg::pin_cmd_t    cmd,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire logic [TIME_WIDTH-1:0] debounce,
  output mpdl_pkg::pin_stat_t        stat
);
  import mpdl_pkg::*;

  logic                  stable;
  logic                  pend;
  logic                  ev;
  logic [TIME_WIDTH-1:0] lockout;

  logic                  stable_next;
  logic                  pend_next;
  logic                  ev_next;
  logic [TIME_WIDTH-1:0] lockout_next;

  logic                  expired;
  logic                  changed;
  logic                  hit_pre;
  logic                  hit_post;
  logic                  ev_mid;
  logic                  stable_mid;

  assign expired = now >= lockout;
  assign changed = cmd.level != stable;

  // sample and query updates
  always_comb begin
    stable_next  = stable;
    pend_next    = pend;
    ev_next      = ev;
    lockout_next = lockout;
    stat         = '0;
    hit_pre      = 1'b0;
    hit_post     = 1'b0;
    ev_mid       = ev;
    stable_mid   = stable;
    if (cmd.do_sample) begin
      if (expired) begin
        if (changed) begin
          ev_next      = 1'b1;
          lockout_next = now + debounce;
        end
        stat.activity = changed || (cmd.level != pend);
        stable_next   = cmd.level;
        pend_next     = cmd.level;
      end else begin
        stat.bounce = changed;
        pend_next   = cmd.level;
      end
    end else if (cmd.do_query) begin
      // report an event already latched at the wanted level
      if (stable == cmd.want) begin
        hit_pre = ev;
        ev_mid  = 1'b0;
      end
      // promote the pending level once the lockout is over
      if (expired) begin
        ev_mid       = pend != stable;
        stable_mid   = pend;
        lockout_next = lockout + debounce;
      end
      if (stable_mid == cmd.want) begin
        hit_post = ev_mid;
        ev_mid   = 1'b0;
      end
      stat.hit    = hit_pre || hit_post;
      ev_next     = ev_mid;
      stable_next = stable_mid;
    end
  end

  // pin state
  always_ff @(posedge clk) begin
    if (rst) begin
      stable  <= 1'b1;
      pend    <= 1'b1;
      ev      <= 1'b0;
      lockout <= '0;
    end else begin
      stable  <= stable_next;
      pend    <= pend_next;
      ev      <= ev_next;
      lockout <= lockout_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mpdl_counters.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpdl_counters
// Saturating phantom and bounce counters with read-clear.
// ----------------------------------------------------------------------------
module mpdl_counters #(
  parameter int NUM = mpdl_pkg::PIN_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       phantom_inc,
  input  wire logic [NUM-1:0]             bounce_vec,
  input  wire logic                       phantom_clr,
  input  wire logic                       bounce_clr,
  output logic      [mpdl_pkg::CTR_W-1:0] phantom_count,
  output logic      [mpdl_pkg::CTR_W-1:0] bounce_count
);
  import mpdl_pkg::*;

  localparam int CW = $clog2(NUM + 1);

  logic [CW-1:0]    bounce_cnt;
  logic [CTR_W:0]   bounce_sum;
  logic [CTR_W-1:0] bounce_count_next;
  logic [CTR_W-1:0] phantom_count_next;

  // bounces in this beat
  always_comb begin
    bounce_cnt = '0;
    for (int i = 0; i < NUM; i++) begin
      bounce_cnt = bounce_cnt + CW'(bounce_vec[i]);
    end
  end

  // saturating updates
  assign bounce_sum = {1'b0, bounce_count} + (CTR_W + 1)'(bounce_cnt);

  always_comb begin
    if (bounce_clr) begin
      bounce_count_next = '0;
    end else if (bounce_sum[CTR_W]) begin
      bounce_count_next = CTR_MAX;
    end else begin
      bounce_count_next = bounce_sum[CTR_W-1:0];
    end
    if (phantom_clr) begin
      phantom_count_next = '0;
    end else if (phantom_inc && (phantom_count != CTR_MAX)) begin
      phantom_count_next = phantom_count + CTR_W'(1);
    end else begin
      phantom_count_next = phantom_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phantom_count <= '0;
      bounce_count  <= '0;
    end else begin
      phantom_count <= phantom_count_next;
      bounce_count  <= bounce_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/multi_pin_debounce_lockout.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_pin_debounce_lockout
// Lockout debouncer for up to eight button lines with event query and
// read-clear phantom and bounce counters.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle, every cycle, as long as results are drained.
// A beat is held in an input register, worked combinationally by the per-pin
// cells and the counters, and a query or counter read lands in the result
// register. Sample beats give no result. Only a full result register with
// out_ready low stalls the input. The lockout compare and add in each pin
// cell is TIME_WIDTH bits wide and sets the critical path. The user must write
// configuration over the APB-style port only while the block is idle; the
// block itself does not enforce this.
module multi_pin_debounce_lockout #(
  parameter int NUM_PINS   = mpdl_pkg::DEF_NUM_PINS,
  parameter int TIME_WIDTH = mpdl_pkg::DEF_TIME_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mpdl_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [mpdl_pkg::DATA_W-1:0]    pwdata,
  output logic      [mpdl_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mpdl_pkg::MODE_W-1:0]    mode,
  input  wire logic [mpdl_pkg::TIME_IN_W-1:0] now_ms,
  input  wire logic [mpdl_pkg::PIN_W-1:0]     pin_levels,
  input  wire logic [mpdl_pkg::QPIN_W-1:0]    query_pin,
  input  wire logic                           want_level,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                pressed,
  output logic      [mpdl_pkg::CTR_W-1:0]     count_value
);
  import mpdl_pkg::*;

  // pins that can ever be enabled
  localparam int ACT_PINS = (NUM_PINS < PIN_W) ? NUM_PINS : PIN_W;

  logic [PIN_W-1:0]      enabled_pins;
  logic [DEB_W-1:0]      debounce_ms;

  logic                  s1_valid;
  mode_t                 s1_mode;
  logic [TIME_IN_W-1:0]  s1_now;
  logic [PIN_W-1:0]      s1_levels;
  logic [QPIN_W-1:0]     s1_qpin;
  logic                  s1_want;

  logic                  fire;
  logic                  has_result;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] deb_t;

  pin_cmd_t              cmd      [ACT_PINS];
  pin_stat_t             stat     [ACT_PINS];
  logic [ACT_PINS-1:0]   activity_vec;
  logic [ACT_PINS-1:0]   bounce_vec;
  logic [ACT_PINS-1:0]   hit_vec;

  logic                  phantom_inc;
  logic [CTR_W-1:0]      phantom_count;
  logic [CTR_W-1:0]      bounce_count;

  assign pready = 1'b1;

  mpdl_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .enabled_pins (enabled_pins),
    .debounce_ms  (debounce_ms)
  );

  // handshake: samples never wait on the result register
  assign has_result = s1_mode != MODE_SAMPLE;
  assign fire       = s1_valid && (!has_result || !out_valid || out_ready);
  assign in_ready   = !s1_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode   <= mode_t'(mode);
      s1_now    <= now_ms;
      s1_levels <= pin_levels;
      s1_qpin   <= query_pin;
      s1_want   <= want_level;
    end
  end

  // time values at the lockout width
  assign now_t = TIME_WIDTH'(s1_now);
  assign deb_t = TIME_WIDTH'(debounce_ms);

  // per-pin cells
  for (genvar i = 0; i < ACT_PINS; i++) begin : g_pin
    always_comb begin
      cmd[i].do_sample = fire && (s1_mode == MODE_SAMPLE) && enabled_pins[i];
      cmd[i].do_query  = fire && (s1_mode == MODE_QUERY) && enabled_pins[i]
                         && (s1_qpin == QPIN_W'(i));
      cmd[i].level     = s1_levels[i];
      cmd[i].want      = s1_want;
    end

    mpdl_pin_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd[i]),
      .now      (now_t),
      .debounce (deb_t),
      .stat     (stat[i])
    );

    assign activity_vec[i] = stat[i].activity;
    assign bounce_vec[i]   = stat[i].bounce;
    assign hit_vec[i]      = stat[i].hit;
  end

  // a sample with no change and no bounce on any pin is a phantom
  assign phantom_inc = fire && (s1_mode == MODE_SAMPLE)
                       && !(|activity_vec) && !(|bounce_vec);

  mpdl_counters #(
    .NUM (ACT_PINS)
  ) u_counters (
    .clk           (clk),
    .rst           (rst),
    .phantom_inc   (phantom_inc),
    .bounce_vec    (bounce_vec),
    .phantom_clr   (fire && (s1_mode == MODE_RD_PHANTOM)),
    .bounce_clr    (fire && (s1_mode == MODE_RD_BOUNCE)),
    .phantom_count (phantom_count),
    .bounce_count  (bounce_count)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      case (s1_mode)
        MODE_QUERY: begin
          pressed     <= |hit_vec;
          count_value <= '0;
        end
        MODE_RD_PHANTOM: begin
          pressed     <= 1'b0;
          count_value <= phantom_count;
        end
        MODE_RD_BOUNCE: begin
          pressed     <= 1'b0;
          count_value <= bounce_count;
        end
        default: begin
          pressed     <= 1'b0;
          count_value <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
